// File: rtl/mlfq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared constants, codes and types of the tick-driven multilevel feedback
// queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  // Table geometry
  localparam int SLOTS  = 64;
  localparam int LEVELS = 4;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDX_W  = $clog2(SLOTS + 1);

  // Field widths
  localparam int MODE_W    = 2;
  localparam int SLOTIN_W  = 6;
  localparam int LVL_W     = 2;
  localparam int SLICE_W   = 8;
  localparam int TICK_W    = 32;
  localparam int PCNT_W    = 7;
  localparam int AGING_W   = 16;
  localparam int NUM_SLICE = 4;

  // Register port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int REG_W  = ADDR_W - 2;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET_RUN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISPATCH = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NEW      = 2'd3;

  // Register indexes
  localparam logic [REG_W-1:0] REG_AGING  = 3'd0;
  localparam logic [REG_W-1:0] REG_SLICE0 = 3'd1;
  localparam logic [REG_W-1:0] REG_SLICE1 = 3'd2;
  localparam logic [REG_W-1:0] REG_SLICE2 = 3'd3;
  localparam logic [REG_W-1:0] REG_SLICE3 = 3'd4;

  // Register defaults
  localparam logic [AGING_W-1:0] AGING_RST = 16'd30;
  localparam logic [NUM_SLICE-1:0][SLICE_W-1:0] SLICE_RST = {8'd15, 8'd9, 8'd3, 8'd1};

  localparam logic [LVL_W-1:0]  LVL_MAX  = LVL_W'(LEVELS - 1);
  localparam logic [PCNT_W-1:0] PCNT_MAX = '1;

  // One slot of the process table
  typedef struct packed {
    logic               runnable;
    logic [LVL_W-1:0]   level;
    logic [SLICE_W-1:0] used;
    logic [TICK_W-1:0]  last;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [AGING_W-1:0]                  aging;
    logic [NUM_SLICE-1:0][SLICE_W-1:0]   slice;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic capture;
    logic scan_step;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_tick;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/mlfq_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_in_if
// Request channel: one scheduler item per transaction.
// ----------------------------------------------------------------------------
interface mlfq_in_if;
  logic                          valid;
  logic                          ready;
  logic [mlfq_pkg::MODE_W-1:0]   mode;
  logic [mlfq_pkg::SLOTIN_W-1:0] slot_index;
  logic                          has_current;
  logic                          runnable_value;

  modport source (output valid, output mode, output slot_index, output has_current,
                  output runnable_value, input ready);
  modport sink   (input valid, input mode, input slot_index, input has_current,
                  input runnable_value, output ready);
endinterface
`default_nettype wire

// File: rtl/mlfq_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_out_if
// Result channel: one scheduler decision per transaction.
// ----------------------------------------------------------------------------
interface mlfq_out_if;
  logic                        valid;
  logic                        ready;
  logic                        yield_now;
  logic                        demoted;
  logic [mlfq_pkg::LVL_W-1:0]  level_now;
  logic [mlfq_pkg::PCNT_W-1:0] promoted_count;

  modport source (output valid, output yield_now, output demoted, output level_now,
                  output promoted_count, input ready);
  modport sink   (input valid, input yield_now, input demoted, input level_now,
                  input promoted_count, output ready);
endinterface
`default_nettype wire

// File: rtl/mlfq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output      logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule
`default_nettype wire

// File: rtl/mlfq_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_cfg
// APB register block: aging wait and the per-level slice lengths.
// ----------------------------------------------------------------------------
module mlfq_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mlfq_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mlfq_pkg::DATA_W-1:0] pwdata,
  output      logic [mlfq_pkg::DATA_W-1:0] prdata,
  output      logic                        pready,
  output      mlfq_pkg::cfg_t              cfg
);

  logic [mlfq_pkg::AGING_W-1:0]                            aging_r;
  logic [mlfq_pkg::NUM_SLICE-1:0][mlfq_pkg::SLICE_W-1:0]   slice_r;
  logic [mlfq_pkg::REG_W-1:0]                              reg_idx;
  logic                                                    wr_en;

  assign reg_idx = paddr[mlfq_pkg::ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aging_r <= mlfq_pkg::AGING_RST;
      slice_r <= mlfq_pkg::SLICE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        mlfq_pkg::REG_AGING:  aging_r    <= pwdata[mlfq_pkg::AGING_W-1:0];
        mlfq_pkg::REG_SLICE0: slice_r[0] <= pwdata[mlfq_pkg::SLICE_W-1:0];
        mlfq_pkg::REG_SLICE1: slice_r[1] <= pwdata[mlfq_pkg::SLICE_W-1:0];
        mlfq_pkg::REG_SLICE2: slice_r[2] <= pwdata[mlfq_pkg::SLICE_W-1:0];
        mlfq_pkg::REG_SLICE3: slice_r[3] <= pwdata[mlfq_pkg::SLICE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    case (reg_idx)
      mlfq_pkg::REG_AGING:  prdata = mlfq_pkg::DATA_W'(aging_r);
      mlfq_pkg::REG_SLICE0: prdata = mlfq_pkg::DATA_W'(slice_r[0]);
      mlfq_pkg::REG_SLICE1: prdata = mlfq_pkg::DATA_W'(slice_r[1]);
      mlfq_pkg::REG_SLICE2: prdata = mlfq_pkg::DATA_W'(slice_r[2]);
      mlfq_pkg::REG_SLICE3: prdata = mlfq_pkg::DATA_W'(slice_r[3]);
      default:              prdata = '0;
    endcase
  end

  assign cfg.aging = aging_r;
  assign cfg.slice = slice_r;

endmodule
`default_nettype wire

// File: rtl/mlfq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer: accept, fetch addressed slot, walk the table on a tick, finish.
// ----------------------------------------------------------------------------
module mlfq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire mlfq_pkg::dp_status_t status,
  output      mlfq_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CUR  = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CUR;
        end
      end
      S_CUR: begin
        cmd.capture = 1'b1;
        state_nxt   = status.is_tick ? S_SCAN : S_FIN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the result register can take the transaction
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/mlfq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_dp
// Datapath: tick counter, slot table RAM with valid bits, aging walk,
// slice accounting and result register.
// ----------------------------------------------------------------------------
module mlfq_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [mlfq_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [mlfq_pkg::SLOTIN_W-1:0] in_slot,
  input  wire logic                          in_cur,
  input  wire logic                          in_rv,
  input  wire mlfq_pkg::cfg_t                cfg,
  input  wire mlfq_pkg::ctrl_cmd_t           cmd,
  output      mlfq_pkg::dp_status_t          status,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic                          out_yield,
  output      logic                          out_demoted,
  output      logic [mlfq_pkg::LVL_W-1:0]    out_level,
  output      logic [mlfq_pkg::PCNT_W-1:0]   out_pcnt
);

  // Latched item
  logic [mlfq_pkg::MODE_W-1:0]   mode_r;
  logic [mlfq_pkg::SLOTIN_W-1:0] slot_r;
  logic                          cur_r;
  logic                          rv_r;
  logic                          exists_r;
  logic                          in_exists;

  // Table state
  logic [mlfq_pkg::TICK_W-1:0]   tick_r;
  logic [mlfq_pkg::SLOTS-1:0]    valid_r;
  logic                          rd_vld_r;

  // Walk state
  mlfq_pkg::slot_rec_t           cur_rec_r;
  logic [mlfq_pkg::IDX_W-1:0]    scan_idx_r;
  logic                          proc_vld_r;
  logic [mlfq_pkg::SLOT_W-1:0]   proc_idx_r;
  logic [mlfq_pkg::PCNT_W-1:0]   pcnt_r;
  logic                          higher_r;
  logic [mlfq_pkg::LVL_W-1:0]    lvl_out_r;
  logic                          scan_last;

  // Result register
  logic                          out_valid_r;
  logic                          out_yield_r;
  logic                          out_dem_r;
  logic [mlfq_pkg::LVL_W-1:0]    out_lvl_r;
  logic [mlfq_pkg::PCNT_W-1:0]   out_pcnt_r;

  // RAM port
  logic                          ram_we, ram_re;
  logic [mlfq_pkg::SLOT_W-1:0]   ram_wa, ram_ra;
  mlfq_pkg::slot_rec_t           ram_wd;
  logic [mlfq_pkg::REC_W-1:0]    ram_rd;
  mlfq_pkg::slot_rec_t           rec_rd;

  // Per-entry walk terms
  logic                          skip;
  logic [mlfq_pkg::TICK_W-1:0]   wait_t;
  logic                          promote;
  logic [mlfq_pkg::LVL_W-1:0]    new_lvl;

  // Finish terms
  mlfq_pkg::slot_rec_t           fin_rec;
  logic                          fin_we;
  logic                          f_yield, f_dem;
  logic [mlfq_pkg::LVL_W-1:0]    f_lvl;
  logic [mlfq_pkg::SLICE_W-1:0]  used_inc;
  logic                          slice_end;

  function automatic logic [mlfq_pkg::SLICE_W-1:0] slice_for(
    input mlfq_pkg::cfg_t c, input logic [mlfq_pkg::LVL_W-1:0] lvl);
    logic [mlfq_pkg::SLICE_W-1:0] s;
    s = c.slice[mlfq_pkg::NUM_SLICE-1];
    if (32'(lvl) < mlfq_pkg::NUM_SLICE - 1) begin
      s = c.slice[lvl];
    end
    return s;
  endfunction

  assign in_exists = (32'(in_slot) < 32'(mlfq_pkg::SLOTS));
  assign scan_last = (scan_idx_r == mlfq_pkg::IDX_W'(mlfq_pkg::SLOTS));

  // Slot table storage
  mlfq_ram #(
    .WIDTH (mlfq_pkg::REC_W),
    .DEPTH (mlfq_pkg::SLOTS)
  ) u_table (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (ram_re),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

  // never-written entries read as the cleared record
  assign rec_rd = rd_vld_r ? mlfq_pkg::slot_rec_t'(ram_rd) : '0;

  // Read address: addressed slot on accept, next entry during the walk
  always_comb begin
    ram_re = 1'b0;
    ram_ra = mlfq_pkg::SLOT_W'(in_slot);
    if (cmd.accept) begin
      ram_re = 1'b1;
    end else if (cmd.scan_step && !scan_last) begin
      ram_re = 1'b1;
      ram_ra = scan_idx_r[mlfq_pkg::SLOT_W-1:0];
    end
  end

  // Aging of the entry fetched last cycle
  always_comb begin
    skip    = cur_r && (proc_idx_r == mlfq_pkg::SLOT_W'(slot_r));
    wait_t  = tick_r - rec_rd.last;
    promote = proc_vld_r && !skip && rec_rd.runnable &&
              (rec_rd.level != '0) &&
              (wait_t >= mlfq_pkg::TICK_W'(cfg.aging));
    new_lvl = promote ? rec_rd.level - mlfq_pkg::LVL_W'(1) : rec_rd.level;
  end

  // Final update of the addressed slot
  always_comb begin
    used_inc  = (cur_rec_r.used == '1) ? cur_rec_r.used
                                       : cur_rec_r.used + mlfq_pkg::SLICE_W'(1);
    slice_end = (used_inc >= slice_for(cfg, cur_rec_r.level));
    fin_rec   = cur_rec_r;
    fin_we    = 1'b0;
    f_yield   = 1'b0;
    f_dem     = 1'b0;
    case (mode_r)
      mlfq_pkg::MODE_TICK: begin
        if (cur_r) begin
          fin_we       = 1'b1;
          fin_rec.used = used_inc;
          if (slice_end) begin
            if (cur_rec_r.level < mlfq_pkg::LVL_MAX) begin
              fin_rec.level = cur_rec_r.level + mlfq_pkg::LVL_W'(1);
              f_dem         = 1'b1;
            end
            fin_rec.used = '0;
            f_yield      = 1'b1;
          end else if (higher_r) begin
            fin_rec.used = '0;
            f_yield      = 1'b1;
          end
        end
      end
      mlfq_pkg::MODE_SET_RUN: begin
        fin_we           = exists_r;
        fin_rec.runnable = rv_r;
      end
      mlfq_pkg::MODE_DISPATCH: begin
        fin_we       = exists_r;
        fin_rec.last = tick_r;
      end
      mlfq_pkg::MODE_NEW: begin
        fin_we       = exists_r;
        fin_rec      = '0;
        fin_rec.last = tick_r;
      end
      default: ;
    endcase
    if (!exists_r) begin
      f_lvl = '0;
    end else if ((mode_r == mlfq_pkg::MODE_TICK) && !cur_r) begin
      f_lvl = lvl_out_r;
    end else begin
      f_lvl = fin_rec.level;
    end
  end

  // Write port: promotions during the walk, slot update at finish
  always_comb begin
    ram_we = 1'b0;
    ram_wa = proc_idx_r;
    ram_wd = rec_rd;
    if (promote) begin
      ram_we       = 1'b1;
      ram_wd.level = new_lvl;
      ram_wd.last  = tick_r;
    end else if (cmd.finish && fin_we) begin
      ram_we = 1'b1;
      ram_wa = mlfq_pkg::SLOT_W'(slot_r);
      ram_wd = fin_rec;
    end
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r   <= in_mode;
      slot_r   <= in_slot;
      cur_r    <= in_cur && in_exists;
      rv_r     <= in_rv;
      exists_r <= in_exists;
    end
    if (ram_re) begin
      rd_vld_r <= valid_r[ram_ra];
    end
    if (cmd.capture) begin
      cur_rec_r <= rec_rd;
    end
    if (cmd.scan_step) begin
      proc_idx_r <= scan_idx_r[mlfq_pkg::SLOT_W-1:0];
    end
  end

  // Control state: tick counter, valid bits, walk counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= '0;
      valid_r    <= '0;
      scan_idx_r <= '0;
      proc_vld_r <= 1'b0;
      pcnt_r     <= '0;
      higher_r   <= 1'b0;
      lvl_out_r  <= '0;
    end else begin
      if (ram_we) begin
        valid_r[ram_wa] <= 1'b1;
      end
      if (cmd.accept) begin
        if (in_mode == mlfq_pkg::MODE_TICK) begin
          tick_r <= tick_r + mlfq_pkg::TICK_W'(1);
        end
        scan_idx_r <= '0;
        proc_vld_r <= 1'b0;
        pcnt_r     <= '0;
        higher_r   <= 1'b0;
      end
      if (cmd.capture) begin
        lvl_out_r <= rec_rd.level;
      end
      if (cmd.scan_step) begin
        proc_vld_r <= !scan_last;
        if (!scan_last) begin
          scan_idx_r <= scan_idx_r + mlfq_pkg::IDX_W'(1);
        end
      end
      if (promote && (pcnt_r != mlfq_pkg::PCNT_MAX)) begin
        pcnt_r <= pcnt_r + mlfq_pkg::PCNT_W'(1);
      end
      if (proc_vld_r && !skip && rec_rd.runnable && cur_r &&
          (new_lvl < cur_rec_r.level)) begin
        higher_r <= 1'b1;
      end
      if (proc_vld_r && (proc_idx_r == mlfq_pkg::SLOT_W'(slot_r))) begin
        lvl_out_r <= new_lvl;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_yield_r <= f_yield;
      out_dem_r   <= f_dem;
      out_lvl_r   <= f_lvl;
      out_pcnt_r  <= (mode_r == mlfq_pkg::MODE_TICK) ? pcnt_r : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_yield   = out_yield_r;
  assign out_demoted = out_dem_r;
  assign out_level   = out_lvl_r;
  assign out_pcnt    = out_pcnt_r;

  assign status.is_tick   = (mode_r == mlfq_pkg::MODE_TICK);
  assign status.scan_done = scan_last;
  assign status.out_free  = !out_valid_r || out_ready;

  // Checks
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_wa != ram_ra))
    else $error("table read and write hit the same entry");

  a_pcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pcnt_r) <= 32'(scan_idx_r))
    else $error("promotion count ahead of the walk");

  a_demote_yields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_dem_r || out_yield_r))
    else $error("demotion reported without yield");

  a_nontick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && (mode_r != mlfq_pkg::MODE_TICK)) |=>
      (!out_yield_r && !out_dem_r && (out_pcnt_r == '0)))
    else $error("non-tick transaction reported tick results");

endmodule
`default_nettype wire

// File: rtl/mlfq_tick_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// Tick item: accepted, addressed slot fetched, then a walk over all slots through the
//   one read port of the slot table, then finish; no new item is accepted until then.
// Set-runnable, dispatch and new-slot items: accept, fetch and finish, without the walk.
// Reset (rst_n low, synchronous): tick counter, slot valid bits and control cleared,
//   registers return to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// mlfq_tick_scheduler
// Tick-driven multilevel feedback queue scheduler: slot table, aging,
// slice accounting and yield decision, with an APB register port.
// ----------------------------------------------------------------------------
module mlfq_tick_scheduler (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  mlfq_in_if.sink                          in_ch,
  mlfq_out_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mlfq_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mlfq_pkg::DATA_W-1:0] pwdata,
  output      logic [mlfq_pkg::DATA_W-1:0] prdata,
  output      logic                        pready
);

  mlfq_pkg::cfg_t       cfg;
  mlfq_pkg::ctrl_cmd_t  cmd;
  mlfq_pkg::dp_status_t status;
  logic                 in_ready;

  // Register block
  mlfq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer
  mlfq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // Datapath
  mlfq_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mode     (in_ch.mode),
    .in_slot     (in_ch.slot_index),
    .in_cur      (in_ch.has_current),
    .in_rv       (in_ch.runnable_value),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_yield   (out_ch.yield_now),
    .out_demoted (out_ch.demoted),
    .out_level   (out_ch.level_now),
    .out_pcnt    (out_ch.promoted_count)
  );

endmodule
`default_nettype wire
